// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the rational arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rau assertion failed");

// Clocked assertion that also holds across reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rau assertion failed");

`endif

// ===== hw/rtl/rau_pkg.sv =====
// Package of the rational arithmetic unit: field widths, word type and operation codes.
package rau_pkg;

    // Port field widths, fixed
    localparam int unsigned RAU_FIELD_BITS = 32;
    localparam int unsigned RAU_OP_BITS    = 3;

    // Default working word width
    localparam int unsigned RAU_WORD_BITS  = 32;

    typedef logic signed [RAU_FIELD_BITS-1:0] t_word;
    typedef logic [RAU_OP_BITS-1:0]           t_op;

    // Operation codes
    localparam t_op OP_REDUCE  = 3'd0;
    localparam t_op OP_ADD     = 3'd1;
    localparam t_op OP_SUB     = 3'd2;
    localparam t_op OP_EQUAL   = 3'd3;
    localparam t_op OP_GREATER = 3'd4;
    localparam t_op OP_INCR    = 3'd5;

endpackage

// ===== hw/rtl/rau_if.sv =====
// Request and result channel interfaces of the rational arithmetic unit.
interface rau_req_if;
    import rau_pkg::*;

    logic  valid;
    logic  ready;
    t_op   op;
    t_word num_a;
    t_word den_a;
    t_word num_b;
    t_word den_b;

    modport source (output valid, op, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, op, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_rsp_if;
    import rau_pkg::*;

    logic  valid;
    logic  ready;
    t_word res_num;
    t_word res_den;
    logic  truth;
    logic  div_zero;

    modport source (output valid, res_num, res_den, truth, div_zero, input ready);
    modport sink   (input valid, res_num, res_den, truth, div_zero, output ready);
endinterface

// ===== hw/rtl/rau_mul.sv =====
// Shared signed multiplier with a registered full-width product.
module rau_mul #(
    parameter int unsigned W = rau_pkg::RAU_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);
    import rau_pkg::*;

    logic signed [2*W-1:0] r_p;

    // exact product, registered
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/rau_div.sv =====
// Radix-2 restoring divider giving truncating quotient and remainder of signed words.
module rau_div #(
    parameter int unsigned W = rau_pkg::RAU_WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_dividend,
    input  logic signed [W-1:0] i_divisor,
    output logic                o_done,
    output logic signed [W-1:0] o_quo,
    output logic signed [W-1:0] o_rem
);
    import rau_pkg::*;

    localparam int unsigned CW = $clog2(W);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIX} t_dv_state;

    t_dv_state           r_state;
    logic [CW-1:0]       r_cnt;
    logic [W-1:0]        r_rem;
    logic [W-1:0]        r_quo;
    logic [W-1:0]        r_bmag;
    logic                r_neg_q;
    logic                r_neg_r;
    logic                r_done;
    logic signed [W-1:0] r_o_quo;
    logic signed [W-1:0] r_o_rem;

    logic [W-1:0]        amag;
    logic [W-1:0]        bmag;
    logic [W:0]          shifted;
    logic [W:0]          diff;

    // magnitudes; the most negative word maps to 2^(W-1), which still fits
    assign amag = i_dividend[W-1] ? (~i_dividend + W'(1)) : i_dividend;
    assign bmag = i_divisor[W-1]  ? (~i_divisor  + W'(1)) : i_divisor;

    // one trial subtraction per cycle
    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_bmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done is a one-cycle strobe, registered from the sign fix-up state
            r_done <= (r_state == DV_FIX);
            unique case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_rem   <= '0;
                        r_quo   <= amag;
                        r_bmag  <= bmag;
                        r_neg_q <= i_dividend[W-1] ^ i_divisor[W-1];
                        r_neg_r <= i_dividend[W-1];
                        r_cnt   <= '0;
                        r_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    if (!diff[W]) begin
                        r_rem <= diff[W-1:0];
                        r_quo <= {r_quo[W-2:0], 1'b1};
                    end else begin
                        r_rem <= shifted[W-1:0];
                        r_quo <= {r_quo[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= DV_FIX;
                    end
                end
                DV_FIX: begin
                    // signs as C gives them: remainder follows the dividend
                    r_o_quo <= r_neg_q ? (~r_quo + W'(1)) : r_quo;
                    r_o_rem <= r_neg_r ? (~r_rem + W'(1)) : r_rem;
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_o_quo;
    assign o_rem  = r_o_rem;

endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
// Rational arithmetic unit: add, subtract, compare, numerator increment and gcd reduction of fractions.
// Compares go from the multiplies straight to the output, as do unused codes from idle.
// Reduce and increment run a Euclid gcd loop of divider remainder steps (at most 45 at
// W = 32), then divide numerator and denominator by the gcd; add and subtract multiply first.
// One request at a time: ready returns together with the result in the output register,
// whose load waits while a result is held. Synchronous active-low reset: idle, output empty.
module rational_arith_unit #(
    parameter int unsigned WORD_BITS = rau_pkg::RAU_WORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);
    import rau_pkg::*;

    localparam int unsigned W = WORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_EVAL, S_RED,
        S_GCD_GO, S_GCD_WAIT, S_QN_GO, S_QN_WAIT, S_QD_GO, S_QD_WAIT, S_OUT
    } t_state;

    t_state                r_state;
    t_op                   r_op;
    logic signed [W-1:0]   r_na;
    logic signed [W-1:0]   r_da;
    logic signed [W-1:0]   r_nb;
    logic signed [W-1:0]   r_db;
    logic signed [2*W-1:0] r_p1;
    logic signed [2*W-1:0] r_p2;
    logic signed [W-1:0]   r_pd;
    logic signed [W-1:0]   r_n;
    logic signed [W-1:0]   r_d;
    logic signed [W-1:0]   r_x;
    logic signed [W-1:0]   r_y;
    logic signed [W-1:0]   r_rs_num;
    logic signed [W-1:0]   r_rs_den;
    logic                  r_rs_truth;
    logic                  r_rs_dz;
    logic                  r_o_valid;
    logic signed [W-1:0]   r_o_num;
    logic signed [W-1:0]   r_o_den;
    logic                  r_o_truth;
    logic                  r_o_dz;

    logic signed [W-1:0]   mul_a;
    logic signed [W-1:0]   mul_b;
    logic signed [2*W-1:0] mul_p;
    logic                  div_start;
    logic signed [W-1:0]   div_a;
    logic signed [W-1:0]   div_b;
    logic                  div_done;
    logic signed [W-1:0]   div_quo;
    logic signed [W-1:0]   div_rem;
    logic                  den_neg;
    logic                  out_free;

    // request fields taken at their low W bits
    logic signed [W-1:0]   in_na;
    logic signed [W-1:0]   in_da;
    logic signed [W-1:0]   in_nb;
    logic signed [W-1:0]   in_db;

    assign in_na = i_req.num_a[W-1:0];
    assign in_da = i_req.den_a[W-1:0];
    assign in_nb = i_req.num_b[W-1:0];
    assign in_db = i_req.den_b[W-1:0];

    // multiplier operand selection: na*db, nb*da, da*db
    always_comb begin
        unique case (r_state)
            S_MUL1: begin
                mul_a = r_nb;
                mul_b = r_da;
            end
            S_MUL2: begin
                mul_a = r_da;
                mul_b = r_db;
            end
            default: begin
                mul_a = r_na;
                mul_b = r_db;
            end
        endcase
    end

    // divider operands: Euclid step x rem y, then n / g and d / g
    always_comb begin
        div_start = 1'b0;
        div_a     = r_x;
        div_b     = r_y;
        unique case (r_state)
            S_GCD_GO: begin
                div_start = 1'b1;
            end
            S_QN_GO: begin
                div_start = 1'b1;
                div_a     = r_n;
                div_b     = r_x;
            end
            S_QD_GO: begin
                div_start = 1'b1;
                div_a     = r_d;
                div_b     = r_x;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    rau_mul #(.W(W)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    rau_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign den_neg  = r_da[W-1] ^ r_db[W-1];
    assign out_free = !r_o_valid || o_rsp.ready;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // taken result leaves unless a new one is loaded this cycle
            if (o_rsp.ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op       <= i_req.op;
                        r_na       <= in_na;
                        r_da       <= in_da;
                        r_nb       <= in_nb;
                        r_db       <= in_db;
                        r_n        <= (i_req.op == OP_INCR) ? (in_na + W'(1)) : in_na;
                        r_d        <= in_da;
                        r_rs_num   <= '0;
                        r_rs_den   <= '0;
                        r_rs_truth <= 1'b0;
                        r_rs_dz    <= 1'b0;
                        unique case (i_req.op)
                            OP_REDUCE: r_state <= S_RED;
                            OP_INCR:   r_state <= S_RED;
                            OP_ADD, OP_SUB, OP_EQUAL, OP_GREATER: r_state <= S_MUL0;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: begin
                    r_p1    <= mul_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= mul_p;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_pd    <= mul_p[W-1:0];
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_op == OP_ADD || r_op == OP_SUB) begin
                        // wrapped sum over wrapped denominator product
                        r_n     <= (r_op == OP_ADD) ? (r_p1[W-1:0] + r_p2[W-1:0])
                                                    : (r_p1[W-1:0] - r_p2[W-1:0]);
                        r_d     <= r_pd;
                        r_state <= S_RED;
                    end else begin
                        // exact cross-product compare, or the divide-by-zero flag on a zero denominator
                        if (r_da == '0 || r_db == '0) begin
                            r_rs_dz <= 1'b1;
                        end else if (r_op == OP_EQUAL) begin
                            r_rs_truth <= (r_p1 == r_p2);
                        end else begin
                            r_rs_truth <= den_neg ? (r_p1 < r_p2) : (r_p1 > r_p2);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_RED: begin
                    if (r_d == '0) begin
                        r_rs_dz <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_x     <= r_n;
                        r_y     <= r_d;
                        r_state <= S_GCD_GO;
                    end
                end
                S_GCD_GO: r_state <= S_GCD_WAIT;
                S_GCD_WAIT: begin
                    if (div_done) begin
                        r_x     <= r_y;
                        r_y     <= div_rem;
                        r_state <= (div_rem == '0) ? S_QN_GO : S_GCD_GO;
                    end
                end
                S_QN_GO: r_state <= S_QN_WAIT;
                S_QN_WAIT: begin
                    if (div_done) begin
                        r_rs_num <= div_quo;
                        r_state  <= S_QD_GO;
                    end
                end
                S_QD_GO: r_state <= S_QD_WAIT;
                S_QD_WAIT: begin
                    if (div_done) begin
                        r_rs_den <= div_quo;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_num   <= r_rs_num;
                        r_o_den   <= r_rs_den;
                        r_o_truth <= r_rs_truth;
                        r_o_dz    <= r_rs_dz;
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.res_num    = RAU_FIELD_BITS'(r_o_num);
    assign o_rsp.res_den    = RAU_FIELD_BITS'(r_o_den);
    assign o_rsp.truth      = r_o_truth;
    assign o_rsp.div_zero   = r_o_dz;

endmodule

// ===== hw/rtl/rau_checker.sv =====
// Port-level checker of the rational arithmetic unit and its bind.
`include "assert_macros.svh"

module rau_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input rau_pkg::t_word        i_rsp_num,
    input rau_pkg::t_word        i_rsp_den,
    input logic                  i_rsp_truth,
    input logic                  i_rsp_dz
);
    import rau_pkg::*;

    // a taken request keeps the unit busy for at least the next cycle
    `ASSERT_CLK(a_busy_after_req, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready)

    // a true compare outcome carries no fraction and no error
    `ASSERT_CLK(a_truth_clean, i_clk, i_rst_n, (i_rsp_valid && i_rsp_truth) |-> (i_rsp_num == '0 && i_rsp_den == '0 && !i_rsp_dz))

    // a zero denominator gives an empty fraction and no truth
    `ASSERT_CLK(a_dz_clean, i_clk, i_rst_n, (i_rsp_valid && i_rsp_dz) |-> (i_rsp_num == '0 && i_rsp_den == '0 && !i_rsp_truth))

    // a stalled result holds
    `ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_num) && $stable(i_rsp_den)))

    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_rsp_valid)

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_num   (o_rsp.res_num),
    .i_rsp_den   (o_rsp.res_den),
    .i_rsp_truth (o_rsp.truth),
    .i_rsp_dz    (o_rsp.div_zero)
);
